### rtl/core/software_timer_table_unit_assert.svh
// ----------------------------------------------------------------------------
// Timer table assertion macros
// Shared concurrent assertion forms, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef SOFTWARE_TIMER_TABLE_UNIT_ASSERT_SVH
`define SOFTWARE_TIMER_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication.
`define STTU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define STTU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/sttu_pkg.sv
// ----------------------------------------------------------------------------
// Timer table package
// Sizes, operation codes and field helpers for the periodic timer table.
// ----------------------------------------------------------------------------
package sttu_pkg;

  localparam int NUM_SLOTS  = 8;
  localparam int COUNT_BITS = 16;

  localparam int SLOT_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int FIRED_W = $clog2(NUM_SLOTS + 1);
  localparam int CMP_W   = (COUNT_BITS > 16) ? COUNT_BITS : 16;

  localparam logic [SLOT_W-1:0]     LAST_IDX = SLOT_W'(NUM_SLOTS - 1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX  = {COUNT_BITS{1'b1}};

  typedef enum logic [2:0] {
    MODE_REGISTER = 3'd0,
    MODE_DELETE   = 3'd1,
    MODE_UPDATE   = 3'd2,
    MODE_TICK     = 3'd3,
    MODE_POLL     = 3'd4
  } mode_e;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_FIRE   = 1'b1;

  function automatic logic [2:0] slot_field(input logic [SLOT_W-1:0] idx);
    logic [SLOT_W+2:0] ext;
    ext = (SLOT_W + 3)'(idx);
    return ext[2:0];
  endfunction

  function automatic logic [3:0] count_field(input logic [FIRED_W-1:0] cnt);
    logic [FIRED_W+3:0] ext;
    ext = (FIRED_W + 4)'(cnt);
    return ext[3:0];
  endfunction

endpackage

### rtl/core/software_timer_table_unit.sv
// ----------------------------------------------------------------------------
// Periodic timer table
// Register, delete and update timer entries; tick and poll fire due entries.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry mode, ticker_id, period, high_priority and active on a
//   valid/stall channel. Output beats carry one result each: zero or more
//   fire events followed by one status beat with last set.
//   After acceptance, the sequencer makes one step per slot through the
//   shared read/compare/increment path, then issues the status beat;
//   unsupported modes skip the slot steps and go straight to the status beat.
//   in_stall_o is high after acceptance until the status beat is loaded, so
//   items are processed one at a time.
//   A fire event is loaded into the output register at the step that
//   examines its slot; the status beat follows the last slot step.
//   When the receiver stalls, the output register holds its beat and the
//   sequencer waits on any slot that needs to emit, so no beat is lost.
//   Reset clears all slot-used flags, the sequencer and the output valid;
//   entry contents are written on register and need no clearing.
// ----------------------------------------------------------------------------
`include "software_timer_table_unit_assert.svh"

module software_timer_table_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  mode_i,
  input  logic [7:0]  ticker_id_i,
  input  logic [15:0] period_i,
  input  logic        high_priority_i,
  input  logic        active_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        kind_o,
  output logic [7:0]  fired_id_o,
  output logic [2:0]  slot_o,
  output logic [15:0] call_count_o,
  output logic        ok_o,
  output logic [3:0]  fired_count_o,
  output logic        last_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_STATUS
  } state_e;

  // slot storage
  logic [7:0]                   ident_mem [sttu_pkg::NUM_SLOTS];
  logic [sttu_pkg::COUNT_BITS-1:0] cnt_mem [sttu_pkg::NUM_SLOTS];
  logic [15:0]                  per_mem   [sttu_pkg::NUM_SLOTS];
  logic                         hp_mem    [sttu_pkg::NUM_SLOTS];
  logic                         act_mem   [sttu_pkg::NUM_SLOTS];
  logic [15:0]                  calls_mem [sttu_pkg::NUM_SLOTS];

  state_e                        state_q, state_d;
  logic [sttu_pkg::NUM_SLOTS-1:0] used_q, used_d;
  sttu_pkg::mode_e               mode_q, mode_d;
  logic [7:0]                    id_q, id_d;
  logic [15:0]                   per_q, per_d;
  logic                          hp_q, hp_d;
  logic                          act_q, act_d;
  logic [sttu_pkg::SLOT_W-1:0]   idx_q, idx_d;
  logic                          found_q, found_d;
  logic [sttu_pkg::SLOT_W-1:0]   found_idx_q, found_idx_d;
  logic                          free_q, free_d;
  logic [sttu_pkg::SLOT_W-1:0]   free_idx_q, free_idx_d;
  logic [sttu_pkg::FIRED_W-1:0]  fired_q, fired_d;

  logic        out_valid_q, out_valid_d;
  logic        kind_q, kind_d;
  logic [7:0]  fired_id_q, fired_id_d;
  logic [2:0]  slot_q, slot_d;
  logic [15:0] call_count_q, call_count_d;
  logic        ok_q, ok_d;
  logic [3:0]  fired_count_q, fired_count_d;
  logic        last_q, last_d;

  // write port
  logic [sttu_pkg::SLOT_W-1:0]     wr_idx;
  logic                            wr_ident, wr_cfg, wr_cnt, wr_calls;
  logic [sttu_pkg::COUNT_BITS-1:0] wr_cnt_data;
  logic [15:0]                     wr_calls_data;

  // shared slot datapath
  logic                            rd_used, rd_hp, rd_act;
  logic [7:0]                      rd_ident;
  logic [sttu_pkg::COUNT_BITS-1:0] rd_cnt, cnt_inc;
  logic [15:0]                     rd_per, rd_calls, calls_inc;
  logic is_tick, is_poll, live, fire, step, out_free, in_accept;
  logic st_ok;
  logic [sttu_pkg::SLOT_W-1:0] st_idx;

  assign rd_used  = used_q[idx_q];
  assign rd_ident = ident_mem[idx_q];
  assign rd_cnt   = cnt_mem[idx_q];
  assign rd_per   = per_mem[idx_q];
  assign rd_hp    = hp_mem[idx_q];
  assign rd_act   = act_mem[idx_q];
  assign rd_calls = calls_mem[idx_q];

  assign is_tick   = (mode_q == sttu_pkg::MODE_TICK);
  assign is_poll   = (mode_q == sttu_pkg::MODE_POLL);
  assign live      = rd_used && rd_act;
  assign cnt_inc   = (is_tick && (rd_cnt != sttu_pkg::CNT_MAX)) ?
                     rd_cnt + sttu_pkg::COUNT_BITS'(1) : rd_cnt;
  assign calls_inc = rd_calls + 16'd1;
  assign fire      = (is_tick || is_poll) && live && (rd_hp == is_tick) &&
                     (sttu_pkg::CMP_W'(cnt_inc) >= sttu_pkg::CMP_W'(rd_per));
  assign out_free  = !out_valid_q || !out_stall_i;
  assign step      = !fire || out_free;
  assign in_accept = in_valid_i && !in_stall_o;

  always_comb begin
    st_ok  = 1'b0;
    st_idx = '0;
    case (mode_q)
      sttu_pkg::MODE_REGISTER: begin
        st_ok  = !found_q && free_q;
        st_idx = free_idx_q;
      end
      sttu_pkg::MODE_DELETE, sttu_pkg::MODE_UPDATE: begin
        st_ok  = found_q;
        st_idx = found_idx_q;
      end
      sttu_pkg::MODE_TICK, sttu_pkg::MODE_POLL: begin
        st_ok = 1'b1;
      end
      default: begin
        st_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d       = state_q;
    used_d        = used_q;
    mode_d        = mode_q;
    id_d          = id_q;
    per_d         = per_q;
    hp_d          = hp_q;
    act_d         = act_q;
    idx_d         = idx_q;
    found_d       = found_q;
    found_idx_d   = found_idx_q;
    free_d        = free_q;
    free_idx_d    = free_idx_q;
    fired_d       = fired_q;
    out_valid_d   = out_valid_q && out_stall_i;
    kind_d        = kind_q;
    fired_id_d    = fired_id_q;
    slot_d        = slot_q;
    call_count_d  = call_count_q;
    ok_d          = ok_q;
    fired_count_d = fired_count_q;
    last_d        = last_q;
    wr_idx        = idx_q;
    wr_ident      = 1'b0;
    wr_cfg        = 1'b0;
    wr_cnt        = 1'b0;
    wr_calls      = 1'b0;
    wr_cnt_data   = cnt_inc;
    wr_calls_data = calls_inc;

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          mode_d  = sttu_pkg::mode_e'(mode_i);
          id_d    = ticker_id_i;
          per_d   = period_i;
          hp_d    = high_priority_i;
          act_d   = active_i;
          idx_d   = '0;
          found_d = 1'b0;
          free_d  = 1'b0;
          fired_d = '0;
          if (mode_i <= 3'(sttu_pkg::MODE_POLL)) begin
            state_d = S_SCAN;
          end else begin
            state_d = S_STATUS;
          end
        end
      end
      S_SCAN: begin
        if (step) begin
          if (rd_used && (rd_ident == id_q) && !found_q) begin
            found_d     = 1'b1;
            found_idx_d = idx_q;
          end
          if (!rd_used && !free_q) begin
            free_d     = 1'b1;
            free_idx_d = idx_q;
          end
          if ((is_tick || is_poll) && live) begin
            wr_cnt      = 1'b1;
            wr_cnt_data = fire ? '0 : cnt_inc;
          end
          if (fire) begin
            wr_calls      = 1'b1;
            fired_d       = fired_q + sttu_pkg::FIRED_W'(1);
            out_valid_d   = 1'b1;
            kind_d        = sttu_pkg::KIND_FIRE;
            fired_id_d    = rd_ident;
            slot_d        = sttu_pkg::slot_field(idx_q);
            call_count_d  = calls_inc;
            ok_d          = 1'b0;
            fired_count_d = '0;
            last_d        = 1'b0;
          end
          if (idx_q == sttu_pkg::LAST_IDX) begin
            state_d = S_STATUS;
          end else begin
            idx_d = idx_q + sttu_pkg::SLOT_W'(1);
          end
        end
      end
      S_STATUS: begin
        if (out_free) begin
          wr_idx = st_idx;
          if (st_ok && (mode_q == sttu_pkg::MODE_REGISTER)) begin
            used_d[st_idx] = 1'b1;
            wr_ident       = 1'b1;
            wr_cfg         = 1'b1;
            wr_cnt         = 1'b1;
            wr_cnt_data    = '0;
            wr_calls       = 1'b1;
            wr_calls_data  = '0;
          end
          if (st_ok && (mode_q == sttu_pkg::MODE_DELETE)) begin
            used_d[st_idx] = 1'b0;
          end
          if (st_ok && (mode_q == sttu_pkg::MODE_UPDATE)) begin
            wr_cfg = 1'b1;
          end
          out_valid_d  = 1'b1;
          kind_d       = sttu_pkg::KIND_STATUS;
          fired_id_d   = (mode_q inside {sttu_pkg::MODE_REGISTER, sttu_pkg::MODE_DELETE,
                                         sttu_pkg::MODE_UPDATE}) ? id_q : 8'd0;
          slot_d       = (st_ok && !is_tick && !is_poll) ?
                         sttu_pkg::slot_field(st_idx) : 3'd0;
          call_count_d = 16'd0;
          ok_d         = st_ok;
          fired_count_d = (is_tick || is_poll) ? sttu_pkg::count_field(fired_q) : 4'd0;
          last_d       = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      used_q        <= '0;
      out_valid_q   <= 1'b0;
      mode_q        <= sttu_pkg::MODE_REGISTER;
      idx_q         <= '0;
      found_q       <= 1'b0;
      free_q        <= 1'b0;
      fired_q       <= '0;
    end else begin
      state_q       <= state_d;
      used_q        <= used_d;
      out_valid_q   <= out_valid_d;
      mode_q        <= mode_d;
      idx_q         <= idx_d;
      found_q       <= found_d;
      free_q        <= free_d;
      fired_q       <= fired_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q          <= id_d;
    per_q         <= per_d;
    hp_q          <= hp_d;
    act_q         <= act_d;
    found_idx_q   <= found_idx_d;
    free_idx_q    <= free_idx_d;
    kind_q        <= kind_d;
    fired_id_q    <= fired_id_d;
    slot_q        <= slot_d;
    call_count_q  <= call_count_d;
    ok_q          <= ok_d;
    fired_count_q <= fired_count_d;
    last_q        <= last_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_ident) begin
      ident_mem[wr_idx] <= id_q;
    end
    if (wr_cfg) begin
      per_mem[wr_idx] <= per_q;
      hp_mem[wr_idx]  <= hp_q;
      act_mem[wr_idx] <= act_q;
    end
    if (wr_cnt) begin
      cnt_mem[wr_idx] <= wr_cnt_data;
    end
    if (wr_calls) begin
      calls_mem[wr_idx] <= wr_calls_data;
    end
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign fired_id_o    = fired_id_q;
  assign slot_o        = slot_q;
  assign call_count_o  = call_count_q;
  assign ok_o          = ok_q;
  assign fired_count_o = fired_count_q;
  assign last_o        = last_q;

  `STTU_ASSERT_NEXT(a_busy_after_accept, in_accept, in_stall_o, "accepted beat did not stall input")
  `STTU_ASSERT_NOW(a_fire_not_last, out_valid_o && (kind_o == sttu_pkg::KIND_FIRE), !last_o, "fire beat marked last")
  `STTU_ASSERT_NOW(a_fired_bound, state_q != S_IDLE, fired_q <= sttu_pkg::FIRED_W'(sttu_pkg::NUM_SLOTS), "fire count overflow")
  `STTU_ASSERT_NEXT(a_status_done, (state_q == S_STATUS) && out_free, (state_q == S_IDLE) && out_valid_o && last_o, "status beat not issued")

endmodule

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// Periodic timer table testbench
// Drives register, delete, update, tick and poll items through the input
// channel with random gaps, drains fire and status beats with random stalls,
// and checks every beat against a shadow copy of the timer table kept in a
// small scoreboard. Directed items cover duplicates, a full table, unknown
// ids, stopped entries, zero periods and the spare modes.
// ----------------------------------------------------------------------------
module tb;

  localparam logic [2:0] SPARE_MODE_FIRST = 3'd5;
  localparam logic [2:0] SPARE_MODE_LAST  = 3'd7;
  localparam int MAX_GAP      = 4;
  localparam int RANDOM_ITEMS = 135;
  localparam int SHOWN_ERRORS = 10;
  localparam int STALL_LIMIT  = 2000;
  localparam int TAIL_CYCLES  = 30;

  typedef struct packed {
    logic        kind;
    logic [7:0]  fired_id;
    logic [2:0]  slot;
    logic [15:0] call_count;
    logic        ok;
    logic [3:0]  fired_count;
    logic        last;
  } beat_t;

  class fire_scoreboard;
    beat_t                           due_beats[$];
    bit                              used     [sttu_pkg::NUM_SLOTS];
    logic [7:0]                      ident    [sttu_pkg::NUM_SLOTS];
    logic [sttu_pkg::COUNT_BITS-1:0] ticks    [sttu_pkg::NUM_SLOTS];
    logic [15:0]                     period   [sttu_pkg::NUM_SLOTS];
    logic                            hi_prio  [sttu_pkg::NUM_SLOTS];
    logic                            running  [sttu_pkg::NUM_SLOTS];
    logic [15:0]                     calls    [sttu_pkg::NUM_SLOTS];
    int                              errors;

    function beat_t make_beat(logic kind, logic [7:0] id, logic [2:0] where,
                              logic [15:0] cnt, logic ok, logic [3:0] fired,
                              logic last);
      beat_t b;
      b.kind        = kind;
      b.fired_id    = id;
      b.slot        = where;
      b.call_count  = cnt;
      b.ok          = ok;
      b.fired_count = fired;
      b.last        = last;
      return b;
    endfunction

    function void note_item(logic [2:0] mode, logic [7:0] id, logic [15:0] per,
                            logic hp, logic act);
      int         hit;
      int         free;
      logic [3:0] fired;
      logic       ok;
      logic [2:0] where;
      hit   = -1;
      free  = -1;
      fired = '0;
      ok    = 1'b0;
      where = '0;
      for (int i = sttu_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
        if (used[i] && ident[i] == id) hit = i;
        if (!used[i]) free = i;
      end
      case (mode)
        sttu_pkg::MODE_REGISTER: if (hit < 0 && free >= 0) begin
          used[free]    = 1'b1;
          ident[free]   = id;
          period[free]  = per;
          hi_prio[free] = hp;
          running[free] = act;
          ticks[free]   = '0;
          calls[free]   = '0;
          ok            = 1'b1;
          where         = 3'(free);
        end
        sttu_pkg::MODE_DELETE, sttu_pkg::MODE_UPDATE: if (hit >= 0) begin
          if (mode == sttu_pkg::MODE_DELETE) begin
            used[hit] = 1'b0;
          end else begin
            period[hit]  = per;
            hi_prio[hit] = hp;
            running[hit] = act;
          end
          ok    = 1'b1;
          where = 3'(hit);
        end
        sttu_pkg::MODE_TICK, sttu_pkg::MODE_POLL: begin
          ok = 1'b1;
          for (int i = 0; i < sttu_pkg::NUM_SLOTS; i++) begin
            if (used[i] && running[i]) begin
              if (mode == sttu_pkg::MODE_TICK && ticks[i] != sttu_pkg::CNT_MAX)
                ticks[i]++;
              if (hi_prio[i] == (mode == sttu_pkg::MODE_TICK) &&
                  ticks[i] >= period[i]) begin
                ticks[i] = '0;
                calls[i]++;
                due_beats.push_back(make_beat(sttu_pkg::KIND_FIRE, ident[i], 3'(i),
                                              calls[i], 1'b0, 4'd0, 1'b0));
                fired++;
              end
            end
          end
        end
        default: ;
      endcase
      due_beats.push_back(make_beat(sttu_pkg::KIND_STATUS,
                                    (mode <= sttu_pkg::MODE_UPDATE) ? id : 8'h00,
                                    where, 16'h0000, ok, fired, 1'b1));
    endfunction

    function void check_beat(beat_t got);
      beat_t want;
      if (due_beats.size() == 0) begin
        errors++;
        if (errors <= SHOWN_ERRORS)
          $display("unexpected beat: kind %0d id %0d slot %0d calls %0d ok %0d fired %0d last %0d",
                   got.kind, got.fired_id, got.slot, got.call_count, got.ok,
                   got.fired_count, got.last);
        return;
      end
      want = due_beats.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= SHOWN_ERRORS) begin
          $display("beat diff exp: kind %0d id %0d slot %0d calls %0d ok %0d fired %0d last %0d",
                   want.kind, want.fired_id, want.slot, want.call_count, want.ok,
                   want.fired_count, want.last);
          $display("         got: kind %0d id %0d slot %0d calls %0d ok %0d fired %0d last %0d",
                   got.kind, got.fired_id, got.slot, got.call_count, got.ok,
                   got.fired_count, got.last);
        end
      end
    endfunction

    function int outstanding();
      return due_beats.size();
    endfunction

    function int failures();
      return errors + due_beats.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  mode_i = '0;
  logic [7:0]  ticker_id_i = '0;
  logic [15:0] period_i = '0;
  logic        high_priority_i = 1'b0;
  logic        active_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        kind_o;
  logic [7:0]  fired_id_o;
  logic [2:0]  slot_o;
  logic [15:0] call_count_o;
  logic        ok_o;
  logic [3:0]  fired_count_o;
  logic        last_o;

  fire_scoreboard sb;
  bit             quiet = 1'b0;
  int             idle_cycles = 0;

  software_timer_table_unit dut (.*);

  always #5 clk_i = ~clk_i;

  task automatic send_item(logic [2:0] mode, logic [7:0] id, logic [15:0] per,
                           logic hp, logic act);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    mode_i          <= mode;
    ticker_id_i     <= id;
    period_i        <= per;
    high_priority_i <= hp;
    active_i        <= act;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_item(mode, id, per, hp, act);
  endtask

  task automatic send_random_item();
    int          pick;
    logic [2:0]  mode;
    logic [7:0]  id;
    logic [15:0] per;
    pick = $urandom_range(0, 99);
    if (pick < 25)      mode = sttu_pkg::MODE_REGISTER;
    else if (pick < 40) mode = sttu_pkg::MODE_DELETE;
    else if (pick < 55) mode = sttu_pkg::MODE_UPDATE;
    else if (pick < 80) mode = sttu_pkg::MODE_TICK;
    else if (pick < 95) mode = sttu_pkg::MODE_POLL;
    else                mode = 3'($urandom_range(SPARE_MODE_FIRST, SPARE_MODE_LAST));
    id   = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 9));
    pick = $urandom_range(0, 9);
    if (pick < 7)       per = 16'($urandom_range(0, 4));
    else if (pick < 9)  per = 16'($urandom_range(0, 15));
    else                per = 16'($urandom);
    send_item(mode, id, per, 1'($urandom), $urandom_range(0, 3) != 0);
  endtask

  // output side: random stall before each beat
  initial begin
    int    hold;
    beat_t got;
    wait (rst_ni === 1'b1);
    forever begin
      hold = quiet ? 0 : $urandom_range(0, MAX_GAP);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      got = {kind_o, fired_id_o, slot_o, call_count_o, ok_o, fired_count_o, last_o};
      sb.check_beat(got);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    sb = new;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed
    send_item(sttu_pkg::MODE_REGISTER, 8'h00, 16'h0000, 1'b1, 1'b1);
    send_item(sttu_pkg::MODE_REGISTER, 8'hFF, 16'hFFFF, 1'b0, 1'b1);
    send_item(sttu_pkg::MODE_REGISTER, 8'h00, 16'h0005, 1'b0, 1'b0);  // duplicate
    send_item(sttu_pkg::MODE_TICK,     8'h00, 16'h0000, 1'b0, 1'b0);
    send_item(sttu_pkg::MODE_POLL,     8'h00, 16'h0000, 1'b0, 1'b0);
    send_item(sttu_pkg::MODE_UPDATE,   8'hFF, 16'h0000, 1'b0, 1'b1);
    send_item(sttu_pkg::MODE_POLL,     8'h00, 16'h0000, 1'b0, 1'b0);
    send_item(sttu_pkg::MODE_UPDATE,   8'h5A, 16'h0003, 1'b1, 1'b1);  // unknown id
    send_item(sttu_pkg::MODE_DELETE,   8'hA5, 16'h0000, 1'b0, 1'b0);  // unknown id
    send_item(sttu_pkg::MODE_REGISTER, 8'h01, 16'h0001, 1'b1, 1'b0);  // stopped
    send_item(sttu_pkg::MODE_REGISTER, 8'h02, 16'h0002, 1'b1, 1'b1);
    send_item(sttu_pkg::MODE_REGISTER, 8'h03, 16'h0000, 1'b0, 1'b0);
    send_item(sttu_pkg::MODE_REGISTER, 8'h04, 16'h0003, 1'b0, 1'b1);
    send_item(sttu_pkg::MODE_REGISTER, 8'h80, 16'h8000, 1'b1, 1'b1);
    send_item(sttu_pkg::MODE_REGISTER, 8'h7F, 16'h0001, 1'b1, 1'b1);
    send_item(sttu_pkg::MODE_REGISTER, 8'h10, 16'h0001, 1'b0, 1'b1);  // table full
    send_item(sttu_pkg::MODE_TICK,     8'h00, 16'h0000, 1'b0, 1'b0);
    send_item(sttu_pkg::MODE_TICK,     8'h00, 16'h0000, 1'b0, 1'b0);
    send_item(sttu_pkg::MODE_POLL,     8'h00, 16'h0000, 1'b0, 1'b0);
    send_item(sttu_pkg::MODE_DELETE,   8'h00, 16'h0000, 1'b0, 1'b0);
    send_item(sttu_pkg::MODE_REGISTER, 8'h10, 16'h0001, 1'b0, 1'b1);
    for (int m = SPARE_MODE_FIRST; m <= SPARE_MODE_LAST; m++)
      send_item(3'(m), 8'hFF, 16'hFFFF, 1'b1, 1'b1);
    send_item(sttu_pkg::MODE_TICK,     8'hFF, 16'hFFFF, 1'b1, 1'b1);

    // random
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 32 == 0) quiet = ($urandom_range(0, 3) == 0);
      send_random_item();
    end

    in_valid_i <= 1'b0;
    quiet = 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.failures() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/sttu_pkg.sv
rtl/core/software_timer_table_unit.sv
tb/sv/tb.sv
